### rtl/mmss_pkg.sv
`timescale 1ns / 1ps

package mmss_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned SPC_W   = 8;

  localparam logic [SPC_W-1:0]   SPC_RESET = 8'd50;
  localparam logic [DIGIT_W-1:0] UNITS_MAX = 4'd9;
  localparam logic [DIGIT_W-1:0] TENS_MAX  = 4'd5;

  localparam logic [1:0] MODE_CODE_RUN    = 2'd0;
  localparam logic [1:0] MODE_CODE_FROZEN = 2'd1;
  localparam logic [1:0] MODE_CODE_ZEROED = 2'd2;

  typedef enum logic [2:0] {
    MODE_RUN    = 3'b001,
    MODE_FROZEN = 3'b010,
    MODE_ZEROED = 3'b100
  } mode_t;

  typedef struct packed {
    logic clr;
    logic inc;
  } cell_ctrl_t;

  // active-low segments, bit 6 = g ... bit 0 = a
  function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h40;
      4'd1:    s = 7'h79;
      4'd2:    s = 7'h24;
      4'd3:    s = 7'h30;
      4'd4:    s = 7'h19;
      4'd5:    s = 7'h12;
      4'd6:    s = 7'h02;
      4'd7:    s = 7'h78;
      4'd8:    s = 7'h00;
      4'd9:    s = 7'h10;
      default: s = 7'h7f;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    case (m)
      MODE_RUN:    c = MODE_CODE_RUN;
      MODE_FROZEN: c = MODE_CODE_FROZEN;
      default:     c = MODE_CODE_ZEROED;
    endcase
    return c;
  endfunction

endpackage

### rtl/mmss_digit_cell.sv
`timescale 1ns / 1ps

module mmss_digit_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mmss_pkg::cell_ctrl_t            ctrl,
  input  logic [mmss_pkg::DIGIT_W-1:0]    max_val,
  output logic [mmss_pkg::DIGIT_W-1:0]    digit,
  output logic [mmss_pkg::DIGIT_W-1:0]    shown,
  output logic [mmss_pkg::SEG_W-1:0]      seg,
  output logic                            carry_out
);
  import mmss_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic               at_max;

  assign at_max    = (digit_r == max_val);
  assign carry_out = ctrl.inc && at_max;
  assign digit     = digit_r;
  assign shown     = ctrl.clr ? '0 : digit_r;
  assign seg       = seg_decode(shown);

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clr) begin
      digit_nxt = '0;
    end else if (ctrl.inc) begin
      digit_nxt = at_max ? '0 : digit_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
    end else begin
      digit_r <= digit_nxt;
    end
  end

endmodule

### rtl/mmss_stopwatch_seven_segment_unit.sv
`timescale 1ns / 1ps

// MM:SS stopwatch for a four-digit common-anode display. Each input request is one
// display refresh slot carrying the debounced button level in in_tdata[0]; each one
// yields exactly one output request with the four BCD digits, their active-low
// segment codes (g..a) and the mode (0 running, 1 frozen, 2 zeroed). A button
// release steps running -> frozen -> zeroed (count cleared) -> running. While
// running, the count advances once every slots_per_count slots (0 acts as 1);
// 59:59 wraps to 00:00. The count lives in a carry chain of four digit cells.
// One request per clock while the result side keeps up: the result is presented in the
// cycle after its slot is taken, and a new slot is taken in the same cycle the previous
// result leaves, so a result held back by out_tready stalls the input.
module mmss_stopwatch_seven_segment_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] button_level, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] minute_tens, [6:3] minute_units, [9:7] second_tens, [13:10] second_units,
  // [20:14] seg_minute_tens, [27:21] seg_minute_units, [34:28] seg_second_tens,
  // [41:35] seg_second_units, [43:42] mode, [47:44] zero
  output logic [47:0] out_tdata
);
  import mmss_pkg::*;

  localparam int unsigned NCELL = 4;

  logic [SPC_W-1:0] spc_r;
  mode_t            mode_r, mode_nxt;
  logic             armed_r;
  logic [SPC_W-1:0] slot_r, slot_nxt;
  logic             out_valid_r;
  logic [47:0]      out_data_r;

  logic             accept;
  logic             level;
  logic             release_ev;
  logic             step;
  logic             clr_count;
  logic [SPC_W:0]   slot_inc;

  cell_ctrl_t             ctrl  [NCELL];
  logic [DIGIT_W-1:0]     maxv  [NCELL];
  logic [DIGIT_W-1:0]     dig   [NCELL];
  logic [DIGIT_W-1:0]     shown [NCELL];
  logic [SEG_W-1:0]       seg   [NCELL];
  logic                   carry [NCELL];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign level      = in_tdata[0];
  assign release_ev = !level && armed_r;
  assign clr_count  = accept && release_ev && (mode_r == MODE_FROZEN);
  assign slot_inc   = {1'b0, slot_r} + 1'b1;
  assign step       = accept && (mode_r == MODE_RUN) && !release_ev &&
                      (slot_inc >= {1'b0, spc_r});

  // cell 0 = second units ... cell 3 = minute tens
  assign maxv[0] = UNITS_MAX;
  assign maxv[1] = TENS_MAX;
  assign maxv[2] = UNITS_MAX;
  assign maxv[3] = TENS_MAX;

  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      assign ctrl[gi].clr = clr_count;
      if (gi == 0) begin : g_first
        assign ctrl[gi].inc = step;
      end else begin : g_next
        assign ctrl[gi].inc = carry[gi-1];
      end
      mmss_digit_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl[gi]),
        .max_val   (maxv[gi]),
        .digit     (dig[gi]),
        .shown     (shown[gi]),
        .seg       (seg[gi]),
        .carry_out (carry[gi])
      );
    end
  endgenerate

  always_comb begin
    mode_nxt = mode_r;
    slot_nxt = slot_r;
    if (accept) begin
      if (release_ev) begin
        case (mode_r)
          MODE_RUN:    mode_nxt = MODE_FROZEN;
          MODE_FROZEN: mode_nxt = MODE_ZEROED;
          default:     mode_nxt = MODE_RUN;
        endcase
        if (mode_r != MODE_RUN) begin
          slot_nxt = '0;
        end
      end else if (mode_r == MODE_RUN) begin
        slot_nxt = step ? '0 : slot_inc[SPC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r       <= SPC_RESET;
      mode_r      <= MODE_RUN;
      armed_r     <= 1'b0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        spc_r <= cfg_wdata;
      end
      mode_r <= mode_nxt;
      slot_r <= slot_nxt;
      if (accept) begin
        armed_r <= level;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {4'b0000, mode_code(mode_nxt),
                     seg[0], seg[1], seg[2], seg[3],
                     shown[0], shown[1][2:0], shown[2], shown[3][2:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode_r == MODE_FROZEN && !release_ev) |=>
      ($stable(dig[0]) && $stable(dig[1]) && $stable(dig[2]) && $stable(dig[3])))
    else $error("count moved while frozen");

  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && release_ev && mode_r == MODE_FROZEN) |=>
      (dig[0] == '0 && dig[1] == '0 && dig[2] == '0 && dig[3] == '0 && slot_r == '0))
    else $error("count not cleared on zeroing");

  a_tens_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dig[1] <= TENS_MAX) && (dig[3] <= TENS_MAX) &&
    (dig[0] <= UNITS_MAX) && (dig[2] <= UNITS_MAX))
    else $error("digit out of range");

endmodule
